// ===== rtl/core/ir_pkg.sv =====
// Package: opcodes, register selects, fault codes and sizes for the instruction executor.
package ir_pkg;
    localparam int NUM_REGS  = 256;
    localparam int MEM_WORDS = 65536;
    localparam int NUM_COND  = 256;
    localparam int RIDX_W    = $clog2(NUM_REGS);
    localparam int MADDR_W   = $clog2(MEM_WORDS);
    localparam int COND_W    = $clog2(NUM_COND);
    localparam int CLR_W     = MADDR_W + 1;

    localparam logic [8:0] SEL_TOS = 9'd256;
    localparam logic [8:0] SEL_ARP = 9'd257;

    localparam logic [1:0] FLT_OK   = 2'd0;
    localparam logic [1:0] FLT_DIV  = 2'd1;
    localparam logic [1:0] FLT_ADDR = 2'd2;
    localparam logic [1:0] FLT_TOS  = 2'd3;

    localparam logic [4:0] OP_ADD     = 5'd0;
    localparam logic [4:0] OP_ADDI    = 5'd1;
    localparam logic [4:0] OP_SUB     = 5'd2;
    localparam logic [4:0] OP_SUBI    = 5'd3;
    localparam logic [4:0] OP_MULT    = 5'd4;
    localparam logic [4:0] OP_MULTI   = 5'd5;
    localparam logic [4:0] OP_DIV     = 5'd6;
    localparam logic [4:0] OP_MOD     = 5'd7;
    localparam logic [4:0] OP_CMPEQ   = 5'd8;
    localparam logic [4:0] OP_CMPGE   = 5'd9;
    localparam logic [4:0] OP_CMPGT   = 5'd10;
    localparam logic [4:0] OP_CMPLE   = 5'd11;
    localparam logic [4:0] OP_CMPLT   = 5'd12;
    localparam logic [4:0] OP_CMPNE   = 5'd13;
    localparam logic [4:0] OP_COMP    = 5'd14;
    localparam logic [4:0] OP_I2I     = 5'd15;
    localparam logic [4:0] OP_LOADI   = 5'd16;
    localparam logic [4:0] OP_LOAD    = 5'd17;
    localparam logic [4:0] OP_STORE   = 5'd18;
    localparam logic [4:0] OP_STOREAO = 5'd19;
    localparam logic [4:0] OP_PUSH    = 5'd20;
    localparam logic [4:0] OP_PUSHI   = 5'd21;
    localparam logic [4:0] OP_POP     = 5'd22;
    localparam logic [4:0] OP_INCRTOS = 5'd23;
    localparam logic [4:0] OP_JUMP    = 5'd24;
    localparam logic [4:0] OP_JUMPI   = 5'd25;
    localparam logic [4:0] OP_CBREQ   = 5'd26;
    localparam logic [4:0] OP_CBRNEQ  = 5'd27;
    localparam logic [4:0] OP_SHOWB   = 5'd28;
    localparam logic [4:0] OP_SHOWI   = 5'd29;
    localparam logic [4:0] OP_HLT     = 5'd31;
endpackage

// ===== rtl/core/ir_instruction_executor_core.sv =====
// Top level: sequenced ILOC-style instruction executor with shared ALU and divider.
//  channel | dir | handshake       | payload
//  s_      | in  | s_valid/s_ready | action, src_a, src_b, dest_reg, cond_index, imm_value, alt_target
//  m_      | out | m_valid/m_ready | next_ip, halted, show_valid, show_value, fault
// From the accepting edge to m_valid: add, addi, sub, subi pass three register reads, operand
// settle and execute; other ops add a memory read; mult and multi further run four 64x16 partial
// products, and div and mod 64 shift-subtract steps, with a zero divisor skipping the divide; while
// halted, idle answers the op directly with halted set. After reset a clearing pass zeroes memory,
// registers and condition bits before s_ready rises. A stalled result holds in the output register;
// s_ready rises the cycle after that result is taken.
module ir_instruction_executor_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_action,
    input  logic [8:0]  s_src_a,
    input  logic [8:0]  s_src_b,
    input  logic [8:0]  s_dest_reg,
    input  logic [7:0]  s_cond_index,
    input  logic signed [63:0] s_imm_value,
    input  logic [15:0] s_alt_target,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_next_ip,
    output logic        m_halted,
    output logic        m_show_valid,
    output logic signed [63:0] m_show_value,
    output logic [1:0]  m_fault
);
    import ir_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RDA   = 4'd2;
    localparam logic [3:0] ST_RDB   = 4'd3;
    localparam logic [3:0] ST_RDD   = 4'd4;
    localparam logic [3:0] ST_MEM   = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_EXEC  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [63:0] regs [NUM_REGS];
    logic [63:0] mem  [MEM_WORDS];
    logic        cond_mem [NUM_COND];
    logic        cbit_reg;

    logic [3:0]  st_reg;
    logic [CLR_W-1:0] clr_reg;
    logic [4:0]  act_reg;
    logic [8:0]  sa_reg, sb_reg, sd_reg;
    logic [7:0]  cc_reg;
    logic [63:0] imm_reg;
    logic [15:0] alt_reg;
    logic [63:0] a_reg, b_reg, d_reg, md_reg;
    logic [63:0] tos_reg, arp_reg;
    logic [15:0] ip_reg;
    logic        run_reg;
    logic [63:0] rf_q;
    logic [8:0]  rsel;
    logic [63:0] acc_reg, rem_reg, quo_reg, dvd_reg;
    logic [6:0]  cnt_reg;
    logic [MADDR_W-1:0] maddr_reg;
    logic        mok_reg;

    logic        mv_reg, mh_reg, msv_reg;
    logic [15:0] mip_reg;
    logic [63:0] msh_reg;
    logic [1:0]  mf_reg;

    assign s_ready      = (st_reg == ST_IDLE) && !mv_reg;
    assign m_valid      = mv_reg;
    assign m_next_ip    = mip_reg;
    assign m_halted     = mh_reg;
    assign m_show_valid = msv_reg;
    assign m_show_value = msh_reg;
    assign m_fault      = mf_reg;

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic slt(input logic [63:0] x, input logic [63:0] y);
        return $signed(x) < $signed(y);
    endfunction

    function automatic logic is_gen(input logic [8:0] s);
        return s < 9'(NUM_REGS);
    endfunction

    always_comb begin
        unique case (st_reg)
            ST_RDA:  rsel = sa_reg;
            ST_RDB:  rsel = sb_reg;
            default: rsel = sd_reg;
        endcase
    end

    function automatic logic [63:0] pick(input logic [8:0] s, input logic [63:0] q,
                                         input logic [63:0] t, input logic [63:0] p);
        if (s == SEL_TOS) return t;
        if (s == SEL_ARP) return p;
        if (is_gen(s)) return q;
        return 64'd0;
    endfunction

    // register file read, registered
    always_ff @(posedge aclk) begin
        rf_q <= regs[rsel[RIDX_W-1:0]];
    end

    logic [63:0] wb_val;
    logic        wb_en;
    logic [1:0]  flt;
    logic        shv;
    logic [63:0] shval;
    logic [15:0] ipn;
    logic [63:0] tosn;
    logic        mem_we;
    logic [63:0] mem_wd;
    logic        cond_we;
    logic        runn;
    logic [63:0] q_fix, r_fix;

    always_comb begin
        wb_val = 64'd0; wb_en = 1'b0; flt = FLT_OK; shv = 1'b0; shval = 64'd0;
        ipn = ip_reg + 16'd1; tosn = tos_reg; mem_we = 1'b0; mem_wd = a_reg;
        cond_we = 1'b0; runn = run_reg;
        q_fix = (a_reg[63] ^ b_reg[63]) ? (~quo_reg + 64'd1) : quo_reg;
        r_fix = a_reg[63] ? (~rem_reg + 64'd1) : rem_reg;
        unique case (act_reg)
            OP_ADD:   begin wb_en = 1'b1; wb_val = acc_reg; end
            OP_ADDI:  begin wb_en = 1'b1; wb_val = acc_reg; end
            OP_SUB:   begin wb_en = 1'b1; wb_val = acc_reg; end
            OP_SUBI:  begin wb_en = 1'b1; wb_val = acc_reg; end
            OP_MULT:  begin wb_en = 1'b1; wb_val = acc_reg; end
            OP_MULTI: begin wb_en = 1'b1; wb_val = acc_reg; end
            OP_DIV, OP_MOD: begin
                if (b_reg == 64'd0) flt = FLT_DIV;
                else begin
                    wb_en = 1'b1;
                    wb_val = (act_reg == OP_DIV) ? q_fix : r_fix;
                end
            end
            OP_CMPEQ: begin wb_en = 1'b1; wb_val = {63'd0, a_reg == b_reg}; end
            OP_CMPGE: begin wb_en = 1'b1; wb_val = {63'd0, !slt(a_reg, b_reg)}; end
            OP_CMPGT: begin wb_en = 1'b1; wb_val = {63'd0, slt(b_reg, a_reg)}; end
            OP_CMPLE: begin wb_en = 1'b1; wb_val = {63'd0, !slt(b_reg, a_reg)}; end
            OP_CMPLT: begin wb_en = 1'b1; wb_val = {63'd0, slt(a_reg, b_reg)}; end
            OP_CMPNE: begin wb_en = 1'b1; wb_val = {63'd0, a_reg != b_reg}; end
            OP_COMP:  cond_we = 1'b1;
            OP_I2I:   begin wb_en = 1'b1; wb_val = a_reg; end
            OP_LOADI: begin wb_en = 1'b1; wb_val = imm_reg; end
            OP_LOAD: begin
                if (!mok_reg) flt = FLT_ADDR;
                else begin wb_en = 1'b1; wb_val = md_reg; end
            end
            OP_STORE, OP_STOREAO: begin
                if (!mok_reg) flt = FLT_ADDR;
                else mem_we = 1'b1;
            end
            OP_PUSH, OP_PUSHI: begin
                if (!mok_reg) flt = FLT_ADDR;
                else begin
                    mem_we = 1'b1;
                    mem_wd = (act_reg == OP_PUSH) ? a_reg : imm_reg;
                    tosn = tos_reg + 64'd1;
                end
            end
            OP_POP: begin
                if (!mok_reg) flt = FLT_ADDR;
                else begin
                    wb_en = 1'b1; wb_val = md_reg;
                    tosn = tos_reg - 64'd1;
                end
            end
            OP_INCRTOS: begin
                if (imm_reg == 64'd1) tosn = tos_reg + 64'd1;
                else if (imm_reg[2:0] == 3'd0) tosn = tos_reg + {{3{imm_reg[63]}}, imm_reg[63:3]};
                else flt = FLT_TOS;
            end
            OP_JUMP:   ipn = a_reg[15:0];
            OP_JUMPI:  ipn = imm_reg[15:0];
            OP_CBREQ:  ipn = cbit_reg ? imm_reg[15:0] : alt_reg;
            OP_CBRNEQ: ipn = cbit_reg ? alt_reg : imm_reg[15:0];
            OP_SHOWB, OP_SHOWI: begin
                if (!mok_reg) flt = FLT_ADDR;
                else begin
                    shv = 1'b1; mem_we = 1'b1;
                    if (act_reg == OP_SHOWB) begin
                        shval = {63'd0, md_reg != 64'd0}; mem_wd = 64'hFFFF_FFFF_FFFF_FFFE;
                    end else begin
                        shval = md_reg; mem_wd = 64'hFFFF_FFFF_FFFF_FFFF;
                    end
                end
            end
            OP_HLT:  runn = 1'b0;
            default: ;
        endcase
        // pop into the stack top decrements the popped word
        if (wb_en && sd_reg == SEL_TOS) tosn = (act_reg == OP_POP) ? wb_val - 64'd1 : wb_val;
    end

    // memory address for the current op, taken after operand reads
    logic [63:0] addr_c;
    always_comb begin
        priority case (act_reg)
            OP_LOAD:               addr_c = a_reg;
            OP_STORE:              addr_c = b_reg;
            OP_STOREAO:            addr_c = b_reg + d_reg;
            OP_PUSH, OP_PUSHI:     addr_c = tos_reg + 64'd1;
            default:               addr_c = tos_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_CLEAR) begin
            mem[clr_reg[MADDR_W-1:0]] <= 64'd0;
        end else if (st_reg == ST_EXEC && mem_we) begin
            mem[maddr_reg] <= mem_wd;
        end
        if (st_reg == ST_OUT) md_reg <= mem[maddr_reg];
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_CLEAR && clr_reg < CLR_W'(NUM_REGS)) begin
            regs[clr_reg[RIDX_W-1:0]] <= 64'd0;
        end else if (st_reg == ST_EXEC && wb_en && is_gen(sd_reg)) begin
            regs[sd_reg[RIDX_W-1:0]] <= wb_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_CLEAR && clr_reg < CLR_W'(NUM_COND)) begin
            cond_mem[clr_reg[COND_W-1:0]] <= 1'b0;
        end else if (st_reg == ST_EXEC && cond_we) begin
            cond_mem[cc_reg] <= (a_reg == b_reg);
        end
        if (st_reg == ST_RDA) cbit_reg <= cond_mem[cc_reg];
    end

    logic [64:0] dv_trial;
    assign dv_trial = {rem_reg, dvd_reg[63]} - {1'b0, mag(b_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLEAR; clr_reg <= '0; mv_reg <= 1'b0;
            tos_reg <= 64'd0; arp_reg <= 64'd0; ip_reg <= 16'd0;
            run_reg <= 1'b1;
        end else begin
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            unique case (st_reg)
                ST_CLEAR: begin
                    if (clr_reg == CLR_W'(MEM_WORDS - 1)) st_reg <= ST_IDLE;
                    clr_reg <= clr_reg + CLR_W'(1);
                end
                ST_IDLE: if (s_valid && s_ready) begin
                    act_reg <= s_action; sa_reg <= s_src_a; sb_reg <= s_src_b;
                    sd_reg <= s_dest_reg; cc_reg <= s_cond_index;
                    imm_reg <= s_imm_value; alt_reg <= s_alt_target;
                    if (run_reg) st_reg <= ST_RDA;
                    else begin
                        mv_reg <= 1'b1; mip_reg <= ip_reg; mh_reg <= 1'b1;
                        msv_reg <= 1'b0; msh_reg <= 64'd0; mf_reg <= FLT_OK;
                    end
                end
                ST_RDA: st_reg <= ST_RDB;
                ST_RDB: begin
                    a_reg <= pick(sa_reg, rf_q, tos_reg, arp_reg);
                    st_reg <= ST_RDD;
                end
                ST_RDD: begin
                    b_reg <= pick(sb_reg, rf_q, tos_reg, arp_reg);
                    st_reg <= ST_MEM;
                end
                ST_MEM: begin
                    d_reg <= pick(sd_reg, rf_q, tos_reg, arp_reg);
                    st_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // operands and address now settled; launch the shared unit
                    maddr_reg <= addr_c[MADDR_W-1:0];
                    mok_reg <= addr_c < 64'(MEM_WORDS);
                    cnt_reg <= 7'd0;
                    rem_reg <= 64'd0; quo_reg <= 64'd0; dvd_reg <= mag(a_reg);
                    priority case (act_reg)
                        OP_ADD:  begin acc_reg <= a_reg + b_reg;   st_reg <= ST_EXEC; end
                        OP_ADDI: begin acc_reg <= a_reg + imm_reg; st_reg <= ST_EXEC; end
                        OP_SUB:  begin acc_reg <= a_reg - b_reg;   st_reg <= ST_EXEC; end
                        OP_SUBI: begin acc_reg <= a_reg - imm_reg; st_reg <= ST_EXEC; end
                        OP_MULT, OP_MULTI: begin acc_reg <= 64'd0; st_reg <= ST_DIV; end
                        OP_DIV, OP_MOD: begin
                            st_reg <= (b_reg == 64'd0) ? ST_OUT : ST_DIV;
                        end
                        default: st_reg <= ST_OUT;
                    endcase
                    if (act_reg == OP_MULTI) b_reg <= imm_reg;
                end
                ST_DIV: begin
                    if (act_reg == OP_MULT || act_reg == OP_MULTI) begin
                        // 16-bit slice of multiplier per cycle, 64x16 partial product
                        acc_reg <= acc_reg + ((a_reg * {48'd0, b_reg[16*cnt_reg[1:0] +: 16]})
                                   << (16 * cnt_reg[1:0]));
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd3) st_reg <= ST_OUT;
                    end else begin
                        dvd_reg <= {dvd_reg[62:0], 1'b0};
                        if (!dv_trial[64]) begin
                            rem_reg <= dv_trial[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[62:0], dvd_reg[63]};
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd63) st_reg <= ST_OUT;
                    end
                end
                ST_OUT: st_reg <= ST_EXEC;
                ST_EXEC: begin
                    ip_reg <= ipn; run_reg <= runn;
                    tos_reg <= tosn;
                    if (wb_en && sd_reg == SEL_ARP) arp_reg <= wb_val;
                    mv_reg <= 1'b1; mip_reg <= ipn; mh_reg <= !runn;
                    msv_reg <= shv; msh_reg <= shval; mf_reg <= flt;
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    a_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> st_reg == ST_IDLE && !mv_reg)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !m_ready |=> mv_reg && $stable(mip_reg))
        else $error("result dropped");
    a_halt_stick: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_reg |=> !run_reg)
        else $error("halt cleared");
endmodule
